>>> rtl/scdp_pkg.sv
// Shared constants, command codes and types of the sparse complex dot product.
package scdp_pkg;

  // List storage and field widths.
  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned PTR_BITS   = $clog2(LIST_DEPTH);
  localparam int unsigned LEN_BITS   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned ACC_BITS   = 64;
  localparam int unsigned CMD_BITS   = 2;

  // Stream packing.
  localparam int unsigned IN_FIELDS_W  = INDEX_BITS + 2 * VALUE_BITS;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 * ACC_BITS + LEN_BITS + 3;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Commands carried in tuser.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_GO       = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  // One stored list entry.
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0] val_im;
    logic [VALUE_BITS-1:0] val_re;
  } entry_t;

  // Request from the merge controller to the multiply-accumulate unit.
  typedef struct packed {
    logic                         clear;
    logic                         start;
    logic signed [VALUE_BITS-1:0] a_re;
    logic signed [VALUE_BITS-1:0] a_im;
    logic signed [VALUE_BITS-1:0] b_re;
    logic signed [VALUE_BITS-1:0] b_im;
  } mac_req_t;

  // Status and sums returned by the multiply-accumulate unit.
  typedef struct packed {
    logic                       busy;
    logic                       sat;
    logic signed [ACC_BITS-1:0] acc_re;
    logic signed [ACC_BITS-1:0] acc_im;
  } mac_rsp_t;

endpackage

>>> rtl/scdp_list_mem.sv
// Storage for one sparse list: synchronous memory with one write and one registered read port.
module scdp_list_mem import scdp_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [PTR_BITS-1:0] waddr_i,
  input  entry_t              wdata_i,
  input  logic [PTR_BITS-1:0] raddr_i,
  output entry_t              rdata_o
);

  entry_t mem_q [LIST_DEPTH];
  entry_t rdata_q;

  // Write on append, read every cycle through a registered output.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/scdp_mac.sv
// Complex multiply-accumulate unit: four products in sequence into saturating accumulators.
module scdp_mac import scdp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  // Product order within one matched pair.
  localparam logic [1:0] TERM_RE_RR = 2'd0;
  localparam logic [1:0] TERM_RE_II = 2'd1;
  localparam logic [1:0] TERM_IM_RI = 2'd2;
  localparam logic [1:0] TERM_IM_IR = 2'd3;

  localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [VALUE_BITS-1:0] ar_q, ai_q, br_q, bi_q;
  logic                         mul_act_q;
  logic [1:0]                   mul_step_q;
  logic                         add_act_q;
  logic [1:0]                   add_step_q;
  logic signed [ACC_BITS-1:0]   prod_q, prod_d;
  logic signed [VALUE_BITS-1:0] mul_a, mul_b;
  logic signed [ACC_BITS-1:0]   acc_re_q, acc_im_q;
  logic                         sat_q;
  logic [ACC_BITS-1:0]          acc_sel, sum, res;
  logic                         is_re, is_sub, ovf;

  // Operand selection and the single multiplier.
  always_comb begin
    case (mul_step_q)
      TERM_RE_RR: begin mul_a = ar_q; mul_b = br_q; end
      TERM_RE_II: begin mul_a = ai_q; mul_b = bi_q; end
      TERM_IM_RI: begin mul_a = ar_q; mul_b = bi_q; end
      default:    begin mul_a = ai_q; mul_b = br_q; end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Saturating add or subtract of the registered product.
  always_comb begin
    is_re   = (add_step_q == TERM_RE_RR) || (add_step_q == TERM_RE_II);
    is_sub  = (add_step_q == TERM_IM_IR);
    acc_sel = is_re ? acc_re_q : acc_im_q;
    sum     = is_sub ? (acc_sel - prod_q) : (acc_sel + prod_q);
    if (is_sub) begin
      ovf = (acc_sel[ACC_BITS-1] != prod_q[ACC_BITS-1]) &&
            (sum[ACC_BITS-1] != acc_sel[ACC_BITS-1]);
    end else begin
      ovf = (acc_sel[ACC_BITS-1] == prod_q[ACC_BITS-1]) &&
            (sum[ACC_BITS-1] != acc_sel[ACC_BITS-1]);
    end
    res = ovf ? (acc_sel[ACC_BITS-1] ? ACC_MIN : ACC_MAX) : sum;
  end

  // Operand and product registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ar_q <= req_i.a_re;
      ai_q <= req_i.a_im;
      br_q <= req_i.b_re;
      bi_q <= req_i.b_im;
    end
    if (mul_act_q) begin
      prod_q <= prod_d;
    end
  end

  // Sequencing and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_act_q  <= 1'b0;
      mul_step_q <= TERM_RE_RR;
      add_act_q  <= 1'b0;
      add_step_q <= TERM_RE_RR;
      acc_re_q   <= '0;
      acc_im_q   <= '0;
      sat_q      <= 1'b0;
    end else begin
      if (req_i.start) begin
        mul_act_q  <= 1'b1;
        mul_step_q <= TERM_RE_RR;
      end else if (mul_act_q) begin
        mul_step_q <= mul_step_q + 2'd1;
        if (mul_step_q == TERM_IM_IR) begin
          mul_act_q <= 1'b0;
        end
      end
      add_act_q  <= mul_act_q;
      add_step_q <= mul_step_q;
      if (req_i.clear) begin
        acc_re_q <= '0;
        acc_im_q <= '0;
        sat_q    <= 1'b0;
      end else if (add_act_q) begin
        if (is_re) begin
          acc_re_q <= res;
        end else begin
          acc_im_q <= res;
        end
        if (ovf) begin
          sat_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy   = mul_act_q | add_act_q;
  assign rsp_o.sat    = sat_q;
  assign rsp_o.acc_re = acc_re_q;
  assign rsp_o.acc_im = acc_im_q;

endmodule

>>> rtl/sparse_complex_dot_product.sv
// Sparse complex dot product: list loading, sorted-merge walk and result register.
//
// Items arrive on the slave stream; tuser carries the command. Command 0 appends an
// entry (index, real, imaginary) to the first list, command 1 to the second list,
// command 2 starts the merge, and command 3 is ignored. Appends are taken whenever
// the merge is not running, also while a result still waits. A merge reads both
// lists from their memories; each walk step is a memory read, then a compare. Each
// matched pair drives the shared multiplier through four products; a further match
// waits until that unit is free. A walk with m matches has at most len_a+len_b-m
// steps; at its end the merge waits for the accumulator to drain, then loads the
// result.
// The result (Q32.32 sums, match count, error flags) is held in an output register;
// if the receiver stalls, a new merge may still run but waits at its end until the
// register is free. After reset both lists are empty and all flags are clear; the
// memories are not cleared, since only entries below a list's length are read.
module sparse_complex_dot_product import scdp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: position [15:0], value_re [47:16], value_im [79:48]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [CMD_BITS-1:0]    s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: sum_re [63:0], sum_im [127:64], match_count [136:128], list_overflow [137],
  //        order_error [138], saturated [139], zero padding above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [LEN_BITS-1:0]   len_a_q, len_a_d, len_b_q, len_b_d;
  logic [LEN_BITS-1:0]   p_q, p_d, q_q, q_d, cnt_q, cnt_d;
  logic [INDEX_BITS-1:0] last_a_q, last_a_d, last_b_q, last_b_d;
  logic                  ovf_q, ovf_d, ord_q, ord_d;
  logic                  out_valid_q, out_valid_d, out_load;
  logic [ACC_BITS-1:0]   out_re_q, out_im_q;
  logic [LEN_BITS-1:0]   out_cnt_q;
  logic                  out_ovf_q, out_ord_q, out_sat_q;

  logic                  in_fire;
  cmd_e                  cmd;
  logic [INDEX_BITS-1:0] in_pos;
  entry_t                wentry, rd_a, rd_b;
  logic                  we_a, we_b;
  mac_req_t              mac_req;
  mac_rsp_t              mac_rsp;

  // Input unpacking.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign in_pos        = s_axis_tdata[INDEX_BITS-1:0];
  assign wentry.index  = in_pos;
  assign wentry.val_re = s_axis_tdata[INDEX_BITS +: VALUE_BITS];
  assign wentry.val_im = s_axis_tdata[INDEX_BITS + VALUE_BITS +: VALUE_BITS];

  // List memories, read at the walk pointers.
  scdp_list_mem u_list_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (len_a_q[PTR_BITS-1:0]),
    .wdata_i (wentry),
    .raddr_i (p_q[PTR_BITS-1:0]),
    .rdata_o (rd_a)
  );

  scdp_list_mem u_list_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (len_b_q[PTR_BITS-1:0]),
    .wdata_i (wentry),
    .raddr_i (q_q[PTR_BITS-1:0]),
    .rdata_o (rd_b)
  );

  scdp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  // Append handling, merge walk and result hand-off.
  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    p_d         = p_q;
    q_d         = q_q;
    cnt_d       = cnt_q;
    last_a_d    = last_a_q;
    last_b_d    = last_b_q;
    ovf_d       = ovf_q;
    ord_d       = ord_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    mac_req       = '0;
    mac_req.a_re  = rd_a.val_re;
    mac_req.a_im  = rd_a.val_im;
    mac_req.b_re  = rd_b.val_re;
    mac_req.b_im  = rd_b.val_im;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_APPEND_A: begin
              if (len_a_q == LEN_BITS'(LIST_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                if ((len_a_q != '0) && (in_pos <= last_a_q)) begin
                  ord_d = 1'b1;
                end
                we_a     = 1'b1;
                last_a_d = in_pos;
                len_a_d  = len_a_q + LEN_BITS'(1);
              end
            end
            CMD_APPEND_B: begin
              if (len_b_q == LEN_BITS'(LIST_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                if ((len_b_q != '0) && (in_pos <= last_b_q)) begin
                  ord_d = 1'b1;
                end
                we_b     = 1'b1;
                last_b_d = in_pos;
                len_b_d  = len_b_q + LEN_BITS'(1);
              end
            end
            CMD_GO: begin
              mac_req.clear = 1'b1;
              p_d           = '0;
              q_d           = '0;
              cnt_d         = '0;
              state_d       = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if ((p_q < len_a_q) && (q_q < len_b_q)) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_CMP: begin
        if (rd_a.index == rd_b.index) begin
          // A match waits here until the multiplier has finished the previous pair.
          if (!mac_rsp.busy) begin
            mac_req.start = 1'b1;
            p_d           = p_q + LEN_BITS'(1);
            q_d           = q_q + LEN_BITS'(1);
            cnt_d         = cnt_q + LEN_BITS'(1);
            state_d       = ST_READ;
          end
        end else if (rd_a.index < rd_b.index) begin
          p_d     = p_q + LEN_BITS'(1);
          state_d = ST_READ;
        end else begin
          q_d     = q_q + LEN_BITS'(1);
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!mac_rsp.busy && (!out_valid_q || m_axis_tready)) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          len_a_d     = '0;
          len_b_d     = '0;
          ovf_d       = 1'b0;
          ord_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      p_q         <= '0;
      q_q         <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      ord_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      p_q         <= p_d;
      q_q         <= q_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      ord_q       <= ord_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Last stored index of each list and the result register.
  always_ff @(posedge clk_i) begin
    last_a_q <= last_a_d;
    last_b_q <= last_b_d;
    if (out_load) begin
      out_re_q  <= mac_rsp.acc_re;
      out_im_q  <= mac_rsp.acc_im;
      out_cnt_q <= cnt_q;
      out_ovf_q <= ovf_q;
      out_ord_q <= ord_q;
      out_sat_q <= mac_rsp.sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                          out_sat_q, out_ord_q, out_ovf_q, out_cnt_q, out_im_q, out_re_q};

`ifndef SYNTHESIS
  // The multiplier is never started while it still works on a previous pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_req.start |-> !mac_rsp.busy)
    else $error("multiply-accumulate started while busy");

  // The walk pointers never run past the list lengths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ((p_q <= len_a_q) && (q_q <= len_b_q)))
    else $error("merge pointer beyond list length");

  // A result is only loaded once the accumulator has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!mac_rsp.busy && (state_q == ST_FINISH)))
    else $error("result loaded while accumulation in flight");

  // List lengths stay within capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LEN_BITS'(LIST_DEPTH)) && (len_b_q <= LEN_BITS'(LIST_DEPTH)))
    else $error("list length beyond capacity");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the sparse complex dot product: stream driver, predictor and monitor.
module tb_top;
  import scdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned ITEM_TARGET  = 1025;
  localparam int unsigned INDEX_MAX    = (1 << INDEX_BITS) - 1;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // One item waiting to be sent; hold makes the sender wait until no sum is owed.
  typedef struct {
    cmd_e                  cmd;
    logic [INDEX_BITS-1:0] pos;
    logic [VALUE_BITS-1:0] re;
    logic [VALUE_BITS-1:0] im;
    bit                    hold;
  } stream_item_t;

  // One dot product result as carried on the master stream.
  typedef struct {
    logic signed [ACC_BITS-1:0] re;
    logic signed [ACC_BITS-1:0] im;
    logic [LEN_BITS-1:0]        count;
    bit                         dropped;
    bit                         misordered;
    bit                         clipped;
  } dot_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_BITS-1:0]    s_axis_tuser = CMD_NOP;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  stream_item_t pending[$];
  dot_result_t  sums_due[$];
  int unsigned  owed_q = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  queued = 0;
  bit           hold_next = 1'b0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;

  // Shadow copy of both lists and the sticky flags.
  logic [INDEX_BITS-1:0]        entry_pos [2][LIST_DEPTH];
  logic signed [VALUE_BITS-1:0] entry_re  [2][LIST_DEPTH];
  logic signed [VALUE_BITS-1:0] entry_im  [2][LIST_DEPTH];
  int unsigned                  list_len  [2];
  bit                           append_dropped;
  bit                           index_misordered;

  sparse_complex_dot_product dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Saturating 64-bit addition; clipped is set when a limit is hit.
  function automatic logic signed [ACC_BITS-1:0] clip_add(
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [ACC_BITS-1:0] term,
    inout bit clipped
  );
    logic signed [ACC_BITS:0] total;
    total = {acc[ACC_BITS-1], acc} + {term[ACC_BITS-1], term};
    if (total[ACC_BITS] != total[ACC_BITS-1]) begin
      clipped = 1'b1;
      return total[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return total[ACC_BITS-1:0];
  endfunction

  // Sorted merge over both shadow lists, accumulating conj(a) * b.
  function automatic dot_result_t merge_product();
    dot_result_t                r;
    int unsigned                p;
    int unsigned                q;
    int unsigned                hits;
    logic signed [ACC_BITS-1:0] prod;
    p = 0;
    q = 0;
    hits = 0;
    r.re = '0;
    r.im = '0;
    r.clipped = 1'b0;
    while (p < list_len[0] && q < list_len[1]) begin
      if (entry_pos[0][p] == entry_pos[1][q]) begin
        prod = entry_re[0][p] * entry_re[1][q];
        r.re = clip_add(r.re, prod, r.clipped);
        prod = entry_im[0][p] * entry_im[1][q];
        r.re = clip_add(r.re, prod, r.clipped);
        prod = entry_re[0][p] * entry_im[1][q];
        r.im = clip_add(r.im, prod, r.clipped);
        prod = entry_im[0][p] * entry_re[1][q];
        r.im = clip_add(r.im, -prod, r.clipped);
        hits++;
        p++;
        q++;
      end else if (entry_pos[0][p] < entry_pos[1][q]) begin
        p++;
      end else begin
        q++;
      end
    end
    r.count = hits[LEN_BITS-1:0];
    r.dropped = append_dropped;
    r.misordered = index_misordered;
    return r;
  endfunction

  // Update the shadow lists for one accepted transfer and record any result it owes.
  task automatic absorb_item(input cmd_e cmd, input logic [INDEX_BITS-1:0] pos,
                             input logic [VALUE_BITS-1:0] re, input logic [VALUE_BITS-1:0] im);
    int unsigned side;
    int unsigned n;
    case (cmd)
      CMD_APPEND_A, CMD_APPEND_B: begin
        side = (cmd == CMD_APPEND_B) ? 1 : 0;
        n = list_len[side];
        if (n >= LIST_DEPTH) begin
          append_dropped = 1'b1;
        end else begin
          if (n > 0 && pos <= entry_pos[side][n-1]) index_misordered = 1'b1;
          entry_pos[side][n] = pos;
          entry_re[side][n] = re;
          entry_im[side][n] = im;
          list_len[side] = n + 1;
        end
      end
      CMD_GO: begin
        sums_due.insert(sums_due.size(), merge_product());
        list_len[0] = 0;
        list_len[1] = 0;
        append_dropped = 1'b0;
        index_misordered = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Monitor: predicts on every input transfer, checks every output transfer.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dot_result_t got;
    dot_result_t want;
    if (!rst_ni) begin
      list_len[0] = 0;
      list_len[1] = 0;
      append_dropped = 1'b0;
      index_misordered = 1'b0;
      owed_q <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_item(cmd_e'(s_axis_tuser), s_axis_tdata[INDEX_BITS-1:0],
                    s_axis_tdata[INDEX_BITS +: VALUE_BITS],
                    s_axis_tdata[INDEX_BITS+VALUE_BITS +: VALUE_BITS]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.re = m_axis_tdata[ACC_BITS-1:0];
        got.im = m_axis_tdata[ACC_BITS +: ACC_BITS];
        got.count = m_axis_tdata[2*ACC_BITS +: LEN_BITS];
        got.dropped = m_axis_tdata[2*ACC_BITS+LEN_BITS];
        got.misordered = m_axis_tdata[2*ACC_BITS+LEN_BITS+1];
        got.clipped = m_axis_tdata[2*ACC_BITS+LEN_BITS+2];
        if (sums_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result transfer with none outstanding: %h", m_axis_tdata);
        end else begin
          want = sums_due.pop_front();
          check_field("sum_re", want.re, got.re);
          check_field("sum_im", want.im, got.im);
          check_field("match_count", 64'(want.count), 64'(got.count));
          check_field("list_overflow", 64'(want.dropped), 64'(got.dropped));
          check_field("order_error", 64'(want.misordered), 64'(got.misordered));
          check_field("saturated", 64'(want.clipped), 64'(got.clipped));
        end
      end
      owed_q <= sums_due.size();
    end
  end

  // Driver: sends pending items in bursts separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit took;
    bit took_go;
    bit show;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= $urandom_range(1, 16);
      gap_left <= 0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      took_go = took && (s_axis_tuser == CMD_GO);
      show = 1'b0;
      if (took) void'(pending.pop_front());
      if (s_axis_tvalid && !s_axis_tready) begin
        show = 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (took && burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        gap_left <= $urandom_range(0, 9);
      end else begin
        if (took) burst_left <= burst_left - 1;
        show = (pending.size() != 0) && !(pending[0].hold && (owed_q != 0 || took_go));
      end
      if (show) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'({pending[0].im, pending[0].re, pending[0].pos});
        s_axis_tuser <= pending[0].cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes character with bits [10:9] of the cycle count.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      case (cycles[10:9])
        2'd0: ;
        2'd1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
        2'd2: if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 30);
        default: if ($urandom_range(0, 1) == 0) stall_left <= 1;
      endcase
    end
  end

  // Cycle count and run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sparse_complex_dot_product test failed");
      $finish;
    end
  end

  task automatic queue_item(input cmd_e cmd, input logic [INDEX_BITS-1:0] pos,
                            input logic [VALUE_BITS-1:0] re, input logic [VALUE_BITS-1:0] im);
    stream_item_t it;
    it.cmd = cmd;
    it.pos = pos;
    it.re = re;
    it.im = im;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending.insert(pending.size(), it);
    if (cmd != CMD_NOP) queued++;
  endtask

  // Mostly full-range values, with extremes and small magnitudes mixed in.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return VALUE_BITS'($urandom_range(0, 131071)) - VALUE_BITS'(65536);
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Append with random content; now and then the index is scrambled to break the order.
  task automatic queue_append(input cmd_e cmd, input int unsigned at);
    if ($urandom_range(0, 15) == 0) at = $urandom_range(0, INDEX_MAX);
    queue_item(cmd, INDEX_BITS'(at), pick_value(), pick_value());
  endtask

  // One mostly well-formed pair of lists followed by a go; fill loads both to capacity and beyond.
  task automatic queue_lists(input int unsigned span, input bit fill);
    int unsigned at;
    int unsigned k;
    int unsigned side;
    at = fill ? $urandom_range(0, INDEX_MAX - LIST_DEPTH) : $urandom_range(0, INDEX_MAX);
    for (k = 0; k < span && at <= INDEX_MAX; k++) begin
      side = fill ? 2 : $urandom_range(0, 3);
      if (side != 1) queue_append(CMD_APPEND_A, at);
      if (side != 0) queue_append(CMD_APPEND_B, at);
      if ($urandom_range(0, 23) == 0)
        queue_item(CMD_NOP, INDEX_BITS'($urandom), $urandom, $urandom);
      if (fill || $urandom_range(0, 7) != 0) at += fill ? 1 : $urandom_range(1, 3);
      else at += $urandom_range(1, 5000);
    end
    if (fill)
      repeat ($urandom_range(1, 3))
        queue_append($urandom_range(0, 1) ? CMD_APPEND_B : CMD_APPEND_A,
                     $urandom_range(0, INDEX_MAX));
    queue_item(CMD_GO, INDEX_BITS'($urandom), $urandom, $urandom);
  endtask

  initial begin : stimulus
    int unsigned seq;
    // Directed part: empty go, unused command, extreme values and indexes.
    queue_item(CMD_GO, '0, '0, '0);
    queue_item(CMD_NOP, '1, '1, '1);
    queue_item(CMD_APPEND_A, '0, VAL_MAX, VAL_MIN);
    queue_item(CMD_APPEND_B, '0, VAL_MIN, VAL_MAX);
    queue_item(CMD_APPEND_A, '1, VAL_MIN, VAL_MIN);
    queue_item(CMD_APPEND_B, '1, VAL_MIN, VAL_MIN);
    queue_item(CMD_GO, '0, '0, '0);
    // Positive clipping of the real sum.
    queue_item(CMD_APPEND_A, 5, VAL_MIN, VAL_MIN);
    queue_item(CMD_APPEND_A, 6, VAL_MIN, VAL_MIN);
    queue_item(CMD_APPEND_B, 5, VAL_MIN, VAL_MIN);
    queue_item(CMD_APPEND_B, 6, VAL_MIN, VAL_MIN);
    queue_item(CMD_GO, '0, '0, '0);
    // Negative clipping of the real sum.
    queue_item(CMD_APPEND_A, 1, VAL_MAX, VAL_MAX);
    queue_item(CMD_APPEND_A, 2, VAL_MAX, VAL_MAX);
    queue_item(CMD_APPEND_B, 1, VAL_MIN, VAL_MIN);
    queue_item(CMD_APPEND_B, 2, VAL_MIN, VAL_MIN);
    queue_item(CMD_GO, '0, '0, '0);
    // Indexes not ascending: stored anyway, merge runs on the stored order.
    queue_item(CMD_APPEND_A, 10, 32'h0001_0000, 32'h0000_8000);
    queue_item(CMD_APPEND_A, 3, 32'hFFFF_0000, 32'h0002_0000);
    queue_item(CMD_APPEND_B, 3, 32'h0003_0000, 32'hFFFE_0000);
    queue_item(CMD_APPEND_B, 10, 32'h0000_4000, 32'h0001_8000);
    queue_item(CMD_GO, '0, '0, '0);
    // Only one list loaded.
    queue_item(CMD_APPEND_A, 7, VAL_MAX, VAL_MAX);
    queue_item(CMD_GO, '0, '0, '0);

    // Random part: mostly well-formed list pairs; the third and now and then another are overfilled.
    seq = 0;
    while (queued < ITEM_TARGET) begin
      if (seq % 5 == 0) hold_next = 1'b1;
      if (seq == 2 || $urandom_range(0, 59) == 0)
        queue_lists(LIST_DEPTH, 1'b1);
      else if ($urandom_range(0, 7) == 0)
        queue_lists($urandom_range(11, 40), 1'b0);
      else
        queue_lists($urandom_range(0, 10), 1'b0);
      seq++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge, once all updates of the rising edge have settled.
    while (pending.size() != 0 || owed_q != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && owed_q == 0) begin
      $display("sparse_complex_dot_product test passed");
    end else begin
      $display("sparse_complex_dot_product test failed");
    end
    $finish;
  end

endmodule
